>>> rtl/ett_pkg.sv
// ----------------------------------------------------------------------------
// ett_pkg: shared types and constants for the expiring token table
// Request codes, the record passed along the cell row and the slot write port.
// ----------------------------------------------------------------------------
package ett_pkg;

  localparam int TOKEN_W = 64;
  localparam int NOW_W   = 48;
  localparam int EXP_W   = 49;
  localparam int LIFE_W  = 40;

  localparam int unsigned US_PER_SECOND = 1000000;
  localparam logic [LIFE_W-1:0] LIFETIME_RESET =
    LIFE_W'(64'd86400 * 64'(US_PER_SECOND));

  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 3;
  localparam logic [APB_ADDR_W-1:0] ADDR_LIFETIME = 3'd0;

  typedef enum logic [1:0] {
    OP_ISSUE  = 2'd0,
    OP_CHECK  = 2'd1,
    OP_REVOKE = 2'd2,
    OP_CLEAR  = 2'd3
  } req_op_t;

  // request record handed from cell to cell, one cell per cycle
  typedef struct packed {
    logic               vld;
    req_op_t            op;
    logic               done;
    logic [TOKEN_W-1:0] tok_hi;
    logic [TOKEN_W-1:0] tok_lo;
    logic [NOW_W-1:0]   now;
    logic [EXP_W-1:0]   min_exp;
  } wave_t;

  typedef struct packed {
    logic               en;
    logic [TOKEN_W-1:0] tok_hi;
    logic [TOKEN_W-1:0] tok_lo;
    logic [EXP_W-1:0]   expiry;
  } slot_wr_t;

endpackage

>>> rtl/ett_cell.sv
// ----------------------------------------------------------------------------
// ett_cell: one slot of the token table
// Holds a slot's token, valid mark and expiry, acts on the passing request
// and hands the updated request record on to the next cell.
// ----------------------------------------------------------------------------
module ett_cell #(
  parameter int IDX_W    = 2,
  parameter int CELL_IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  ett_pkg::wave_t    wave_in,
  input  logic [IDX_W-1:0]  pick_in,
  input  ett_pkg::slot_wr_t wr,
  output ett_pkg::wave_t    wave_out,
  output logic [IDX_W-1:0]  pick_out
);
  import ett_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic               valid;
  logic               valid_next;
  logic [EXP_W-1:0]   expiry;
  logic [EXP_W-1:0]   expiry_next;
  logic [TOKEN_W-1:0] tok_hi;
  logic [TOKEN_W-1:0] tok_lo;
  wave_t              wave_next;
  logic [IDX_W-1:0]   pick_next;
  logic               expired;
  logic               match;

  assign expired = expiry <= {1'b0, wave_in.now};
  assign match   = valid && (tok_hi == wave_in.tok_hi) && (tok_lo == wave_in.tok_lo);

  always_comb begin
    valid_next  = valid;
    expiry_next = expiry;
    wave_next   = wave_in;
    pick_next   = pick_in;
    if (wave_in.vld) begin
      case (wave_in.op)
        OP_ISSUE: begin
          if (!wave_in.done) begin
            if (!valid || expired) begin
              wave_next.done = 1'b1;
              pick_next      = MY_IDX;
            end else if ((CELL_IDX == 0) || (expiry < wave_in.min_exp)) begin
              // earliest expiry so far, ties stay with the lower slot
              wave_next.min_exp = expiry;
              pick_next         = MY_IDX;
            end
          end
        end
        OP_CHECK: begin
          if (!wave_in.done) begin
            if (expired) begin
              valid_next = 1'b0;
            end else if (match) begin
              wave_next.done = 1'b1;
              pick_next      = MY_IDX;
            end
          end
        end
        OP_REVOKE: begin
          if (!wave_in.done && match) begin
            valid_next     = 1'b0;
            expiry_next    = '0;
            wave_next.done = 1'b1;
            pick_next      = MY_IDX;
          end
        end
        OP_CLEAR: begin
          valid_next  = 1'b0;
          expiry_next = '0;
        end
        default: begin
          valid_next = valid;
        end
      endcase
    end
    // issue write-back from the end of the row
    if (wr.en) begin
      valid_next  = 1'b1;
      expiry_next = wr.expiry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= 1'b0;
      expiry       <= '0;
      wave_out.vld <= 1'b0;
    end else begin
      valid        <= valid_next;
      expiry       <= expiry_next;
      wave_out.vld <= wave_next.vld;
    end
    wave_out.op      <= wave_next.op;
    wave_out.done    <= wave_next.done;
    wave_out.tok_hi  <= wave_next.tok_hi;
    wave_out.tok_lo  <= wave_next.tok_lo;
    wave_out.now     <= wave_next.now;
    wave_out.min_exp <= wave_next.min_exp;
    pick_out         <= pick_next;
    if (wr.en) begin
      tok_hi <= wr.tok_hi;
      tok_lo <= wr.tok_lo;
    end
  end

endmodule

>>> rtl/expiring_token_table.sv
// ----------------------------------------------------------------------------
// expiring_token_table: session token table with per-entry expiry
// A request enters a row of slot cells and visits one cell per cycle; issue
// writes its chosen slot once the request leaves the last cell.
// ----------------------------------------------------------------------------
// the request passes the entry register, each cell register in row order, then the done register
// busy covers the whole walk; a new request is taken only after the last one leaves the row
// the walk along the cell row, one slot per cycle, sets how long busy stays high
// results are shown for one cycle on done; the receiver cannot stall
// reset: synchronous, empties every slot and loads the one-day lifetime
module expiring_token_table #(
  parameter int SLOTS = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       req_type,
  input  logic [ett_pkg::TOKEN_W-1:0]      token_high,
  input  logic [ett_pkg::TOKEN_W-1:0]      token_low,
  input  logic [ett_pkg::NOW_W-1:0]        now_us,
  output logic                             done,
  output logic                             ok,
  output logic [1:0]                       slot_index,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ett_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [ett_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [ett_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import ett_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);

  logic [LIFE_W-1:0] lifetime;
  logic              accept;
  logic              cfg_wr;
  logic [EXP_W-1:0]  exp_new;
  wave_t             wave [SLOTS+1];
  logic [IDX_W-1:0]  pick [SLOTS+1];
  slot_wr_t          wr   [SLOTS];
  wave_t             last;
  logic              busy_next;
  logic [SLOTS:0]    wave_vld;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_LIFETIME);
  assign prdata = (paddr == ADDR_LIFETIME) ? APB_DATA_W'(lifetime) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      lifetime <= LIFETIME_RESET;
    end else if (cfg_wr) begin
      lifetime <= pwdata[LIFE_W-1:0];
    end
  end

  assign accept = start && !busy;

  // entry register feeding the first cell
  always_ff @(posedge clk) begin
    if (rst) begin
      wave[0].vld <= 1'b0;
    end else begin
      wave[0].vld <= accept;
    end
    if (accept) begin
      wave[0].op      <= req_op_t'(req_type);
      wave[0].done    <= 1'b0;
      wave[0].tok_hi  <= token_high;
      wave[0].tok_lo  <= token_low;
      wave[0].now     <= now_us;
      wave[0].min_exp <= '0;
      exp_new         <= {1'b0, now_us} + EXP_W'(lifetime);
    end
  end

  assign pick[0] = '0;
  assign last    = wave[SLOTS];

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign wr[i].en     = last.vld && (last.op == OP_ISSUE) &&
                          (pick[SLOTS] == IDX_W'(i));
    assign wr[i].tok_hi = last.tok_hi;
    assign wr[i].tok_lo = last.tok_lo;
    assign wr[i].expiry = exp_new;

    ett_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wave_in  (wave[i]),
      .pick_in  (pick[i]),
      .wr       (wr[i]),
      .wave_out (wave[i+1]),
      .pick_out (pick[i+1])
    );
  end

  always_comb begin
    busy_next = busy;
    if (accept) begin
      busy_next = 1'b1;
    end else if (last.vld) begin
      busy_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= busy_next;
      done <= last.vld;
    end
  end

  // result register, slot number reported modulo four
  always_ff @(posedge clk) begin
    if (last.vld) begin
      ok <= (last.op == OP_ISSUE) || (last.op == OP_CLEAR) || last.done;
      if (last.op == OP_CLEAR || (last.op != OP_ISSUE && !last.done)) begin
        slot_index <= '0;
      end else begin
        slot_index <= 2'(pick[SLOTS]);
      end
    end
  end

  for (genvar j = 0; j <= SLOTS; j++) begin : g_vld
    assign wave_vld[j] = wave[j].vld;
  end

  // at most one transaction in the row at a time
  a_one_wave: assert property (@(posedge clk) disable iff (rst) $onehot0(wave_vld))
    else $error("more than one transaction in the cell row");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after a transaction was taken");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while still busy");

  a_exit_done: assert property (@(posedge clk) disable iff (rst) last.vld |=> done)
    else $error("transaction left the row without a result");

  a_wave_busy: assert property (@(posedge clk) disable iff (rst)
    (wave_vld != '0) |-> busy)
    else $error("transaction in the row while not busy");

endmodule
